@@ hw/rtl/gcbl_pkg.sv @@
`timescale 1ns / 1ps

package gcbl_pkg;

    localparam int COORD_BITS_DEF      = 24;
    localparam int MAX_AXIS_CHUNKS_DEF = 16;

    localparam int IDX_W   = 12;
    localparam int CELL_W  = 4;
    localparam int TOTAL_W = 13;
    localparam int LIMIT_W = 5;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    typedef enum logic [2:0] {
        REG_MIN_X    = 3'd0,
        REG_MIN_Y    = 3'd1,
        REG_MIN_Z    = 3'd2,
        REG_MAX_X    = 3'd3,
        REG_MAX_Y    = 3'd4,
        REG_MAX_Z    = 3'd5,
        REG_CHUNK_SZ = 3'd6,
        REG_AXIS_LIM = 3'd7
    } t_reg_idx;

endpackage

@@ hw/rtl/gcbl_if.sv @@
`timescale 1ns / 1ps

interface gcbl_req_if;
    import gcbl_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] chunk_index;

    modport source (output valid, output chunk_index, input ready);
    modport sink   (input valid, input chunk_index, output ready);
endinterface

interface gcbl_rsp_if #(
    parameter int COORD_BITS = gcbl_pkg::COORD_BITS_DEF
);
    import gcbl_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         index_valid;
    logic [CELL_W-1:0]            cell_x;
    logic [CELL_W-1:0]            cell_y;
    logic [CELL_W-1:0]            cell_z;
    logic signed [COORD_BITS-1:0] box_min_x;
    logic signed [COORD_BITS-1:0] box_min_y;
    logic signed [COORD_BITS-1:0] box_min_z;
    logic signed [COORD_BITS-1:0] box_max_x;
    logic signed [COORD_BITS-1:0] box_max_y;
    logic signed [COORD_BITS-1:0] box_max_z;
    logic [TOTAL_W-1:0]           chunk_total;

    modport source (
        output valid, input ready, output index_valid, output cell_x, output cell_y,
        output cell_z, output box_min_x, output box_min_y, output box_min_z,
        output box_max_x, output box_max_y, output box_max_z, output chunk_total
    );
    modport sink (
        input valid, output ready, input index_valid, input cell_x, input cell_y,
        input cell_z, input box_min_x, input box_min_y, input box_min_z,
        input box_max_x, input box_max_y, input box_max_z, input chunk_total
    );
endinterface

@@ hw/rtl/gcbl_cfg.sv @@
`timescale 1ns / 1ps

module gcbl_cfg #(
    parameter int COORD_BITS = gcbl_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gcbl_pkg::APB_AW-1:0]   paddr,
    input  logic [gcbl_pkg::APB_DW-1:0]   pwdata,
    output logic [gcbl_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output logic [COORD_BITS-1:0]         o_lo [3],
    output logic [COORD_BITS-1:0]         o_hi [3],
    output logic [COORD_BITS-1:0]         o_chunk_sz,
    output logic [gcbl_pkg::LIMIT_W-1:0]  o_axis_lim
);
    import gcbl_pkg::*;

    logic [COORD_BITS-1:0] r_lo [3];
    logic [COORD_BITS-1:0] r_hi [3];
    logic [COORD_BITS-1:0] r_chunk_sz;
    logic [LIMIT_W-1:0]    r_axis_lim;
    t_reg_idx              w_idx;
    logic                  w_wr;

    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_lo[a] <= '0;
                r_hi[a] <= '0;
            end
            r_chunk_sz <= '0;
            r_axis_lim <= LIMIT_W'(1);
        end else if (w_wr) begin
            case (w_idx)
                REG_MIN_X:    r_lo[0]    <= pwdata[COORD_BITS-1:0];
                REG_MIN_Y:    r_lo[1]    <= pwdata[COORD_BITS-1:0];
                REG_MIN_Z:    r_lo[2]    <= pwdata[COORD_BITS-1:0];
                REG_MAX_X:    r_hi[0]    <= pwdata[COORD_BITS-1:0];
                REG_MAX_Y:    r_hi[1]    <= pwdata[COORD_BITS-1:0];
                REG_MAX_Z:    r_hi[2]    <= pwdata[COORD_BITS-1:0];
                REG_CHUNK_SZ: r_chunk_sz <= pwdata[COORD_BITS-1:0];
                REG_AXIS_LIM: r_axis_lim <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_MIN_X:    prdata = APB_DW'(r_lo[0]);
            REG_MIN_Y:    prdata = APB_DW'(r_lo[1]);
            REG_MIN_Z:    prdata = APB_DW'(r_lo[2]);
            REG_MAX_X:    prdata = APB_DW'(r_hi[0]);
            REG_MAX_Y:    prdata = APB_DW'(r_hi[1]);
            REG_MAX_Z:    prdata = APB_DW'(r_hi[2]);
            REG_CHUNK_SZ: prdata = APB_DW'(r_chunk_sz);
            REG_AXIS_LIM: prdata = APB_DW'(r_axis_lim);
            default:      prdata = '0;
        endcase
    end

    assign o_lo       = r_lo;
    assign o_hi       = r_hi;
    assign o_chunk_sz = r_chunk_sz;
    assign o_axis_lim = r_axis_lim;

endmodule

@@ hw/rtl/grid_chunk_bounds_lookup.sv @@
`timescale 1ns / 1ps
// Chunk bounds lookup: seven register stages from request accept to result
// valid. Throughput one request per cycle; the whole pipe holds only while
// the output stage is full and not taken.
// Divisions come from compares against multiples of the chunk size, quotients
// from reciprocal multiplies. Synchronous active-low reset clears the valid
// bits and restores the configuration registers to their defaults.

module grid_chunk_bounds_lookup #(
    parameter int COORD_BITS      = gcbl_pkg::COORD_BITS_DEF,
    parameter int MAX_AXIS_CHUNKS = gcbl_pkg::MAX_AXIS_CHUNKS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    gcbl_req_if.sink                    i_req,
    gcbl_rsp_if.source                  o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gcbl_pkg::APB_AW-1:0] paddr,
    input  logic [gcbl_pkg::APB_DW-1:0] pwdata,
    output logic [gcbl_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import gcbl_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int DB   = $clog2(MAX_AXIS_CHUNKS + 1);
    localparam int ND   = 2 ** DB;
    localparam int KW   = C + DB;
    localparam int S    = C + DB;
    localparam int RCW  = S + 1;
    localparam int SI   = IDX_W + DB;
    localparam int RIW  = SI + 1;
    localparam int TW   = 3 * DB;

    logic [C-1:0]       w_lo [3];
    logic [C-1:0]       w_hi [3];
    logic [C-1:0]       w_mcs;
    logic [LIMIT_W-1:0] w_axis_lim;

    gcbl_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_lo       (w_lo),
        .o_hi       (w_hi),
        .o_chunk_sz (w_mcs),
        .o_axis_lim (w_axis_lim)
    );

    // reciprocal tables, ceil(2^S / d) and ceil(2^SI / d)
    logic [RCW-1:0] w_rc [ND];
    logic [RIW-1:0] w_ri [ND];

    for (genvar d = 0; d < ND; d++) begin : g_recip
        if (d >= 1 && d <= MAX_AXIS_CHUNKS) begin : g_on
            localparam logic [63:0] RC = ((64'd1 << S) + 64'(d) - 64'd1) / 64'(d);
            localparam logic [63:0] RI = ((64'd1 << SI) + 64'(d) - 64'd1) / 64'(d);
            assign w_rc[d] = RC[RCW-1:0];
            assign w_ri[d] = RI[RIW-1:0];
        end else begin : g_off
            assign w_rc[d] = '0;
            assign w_ri[d] = '0;
        end
    end

    logic w_en;

    // stage 1
    logic [KW-1:0]    w_mult [MAX_AXIS_CHUNKS];
    logic [C:0]       w_szf [3];
    logic [7:0]       w_lim8;
    logic [DB-1:0]    w_lim;
    logic             w_single;

    logic             r1_v;
    logic [IDX_W-1:0] r1_idx;
    logic [C-1:0]     r1_sz [3];
    logic             r1_single;
    logic [DB-1:0]    r1_lim;
    logic [KW-1:0]    r1_mult [MAX_AXIS_CHUNKS];

    for (genvar k = 0; k < MAX_AXIS_CHUNKS; k++) begin : g_mult
        assign w_mult[k] = KW'(w_mcs) * KW'(k + 1);
    end

    always_comb begin
        w_lim8 = 8'(w_axis_lim);
        if (w_lim8 > 8'(MAX_AXIS_CHUNKS)) begin
            w_lim8 = 8'(MAX_AXIS_CHUNKS);
        end
        w_lim    = w_lim8[DB-1:0];
        w_single = (w_mcs == '0) || (w_lim8 == 8'd0);
        for (int a = 0; a < 3; a++) begin
            w_szf[a] = {w_hi[a][C-1], w_hi[a]} - {w_lo[a][C-1], w_lo[a]};
            if (w_szf[a][C]) begin
                w_single = 1'b1;
            end
        end
    end

    // stage 2
    logic [DB-1:0]    w_div [3];
    logic             r2_v;
    logic [IDX_W-1:0] r2_idx;
    logic [C-1:0]     r2_sz [3];
    logic [DB-1:0]    r2_div [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_div[a] = r1_lim;
            for (int k = MAX_AXIS_CHUNKS; k >= 1; k--) begin
                if ((DB'(k) <= r1_lim) && (KW'(r1_sz[a]) <= r1_mult[k-1])) begin
                    w_div[a] = DB'(k);
                end
            end
            if (r1_single || (r1_sz[a] == '0)) begin
                w_div[a] = DB'(1);
            end
        end
    end

    // stage 3
    logic                   r3_v;
    logic [IDX_W-1:0]       r3_idx;
    logic [DB-1:0]          r3_div [3];
    logic [2*DB-1:0]        r3_p01;
    logic [C+RCW-1:0]       r3_csp [3];
    logic [IDX_W+RIW-1:0]   r3_rp;

    // stage 4
    logic [IDX_W-1:0]       w4_rest;
    logic [IDX_W+DB-1:0]    w4_rd;
    logic                   r4_v;
    logic [IDX_W-1:0]       r4_idx;
    logic [DB-1:0]          r4_div [3];
    logic [TW-1:0]          r4_total;
    logic [C-1:0]           r4_cs [3];
    logic [IDX_W-1:0]       r4_rest;
    logic [DB-1:0]          r4_cell2;
    logic [IDX_W+RIW-1:0]   r4_r2p;

    assign w4_rest = r3_rp[SI +: IDX_W];
    assign w4_rd   = (IDX_W+DB)'(w4_rest) * (IDX_W+DB)'(r3_div[2]);

    // stage 5
    logic [IDX_W-1:0]       w5_r2;
    logic [IDX_W+DB-1:0]    w5_rd;
    logic                   r5_v;
    logic                   r5_ok;
    logic [DB-1:0]          r5_div [3];
    logic [TW-1:0]          r5_total;
    logic [C-1:0]           r5_cs [3];
    logic [DB-1:0]          r5_cell [3];

    assign w5_r2 = r4_r2p[SI +: IDX_W];
    assign w5_rd = (IDX_W+DB)'(w5_r2) * (IDX_W+DB)'(r4_div[1]);

    // stage 6
    logic                   r6_v;
    logic                   r6_ok;
    logic [TW-1:0]          r6_total;
    logic [C-1:0]           r6_cs [3];
    logic [DB-1:0]          r6_cell [3];
    logic [C-1:0]           r6_prod [3];
    logic                   r6_last [3];

    // stage 7
    logic [C-1:0]           w7_bmin [3];
    logic [CELL_W+DB-1:0]   w7_cell [3];
    logic [TOTAL_W+TW-1:0]  w7_total;
    logic                   r7_v;
    logic                   r7_ok;
    logic [CELL_W-1:0]      r7_cell [3];
    logic [C-1:0]           r7_bmin [3];
    logic [C-1:0]           r7_bmax [3];
    logic [TOTAL_W-1:0]     r7_total;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w7_bmin[a] = w_lo[a] + r6_prod[a];
            w7_cell[a] = (CELL_W+DB)'(r6_cell[a]);
        end
        w7_total = (TOTAL_W+TW)'(r6_total);
    end

    assign w_en        = !r7_v || o_rsp.ready;
    assign i_req.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_req.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_idx    <= i_req.chunk_index;
            r1_single <= w_single;
            r1_lim    <= w_lim;
            r1_mult   <= w_mult;
            for (int a = 0; a < 3; a++) begin
                r1_sz[a] <= w_szf[a][C-1:0];
            end

            r2_idx <= r1_idx;
            r2_sz  <= r1_sz;
            r2_div <= w_div;

            r3_idx <= r2_idx;
            r3_div <= r2_div;
            r3_p01 <= (2*DB)'(r2_div[0]) * (2*DB)'(r2_div[1]);
            for (int a = 0; a < 3; a++) begin
                r3_csp[a] <= (C+RCW)'(r2_sz[a]) * (C+RCW)'(w_rc[r2_div[a]]);
            end
            r3_rp <= (IDX_W+RIW)'(r2_idx) * (IDX_W+RIW)'(w_ri[r2_div[2]]);

            r4_idx   <= r3_idx;
            r4_div   <= r3_div;
            r4_total <= TW'(r3_p01) * TW'(r3_div[2]);
            for (int a = 0; a < 3; a++) begin
                r4_cs[a] <= r3_csp[a][S +: C];
            end
            r4_rest  <= w4_rest;
            r4_cell2 <= DB'(r3_idx - w4_rd[IDX_W-1:0]);
            r4_r2p   <= (IDX_W+RIW)'(w4_rest) * (IDX_W+RIW)'(w_ri[r3_div[1]]);

            r5_ok      <= (TW+IDX_W)'(r4_idx) < (TW+IDX_W)'(r4_total);
            r5_div     <= r4_div;
            r5_total   <= r4_total;
            r5_cs      <= r4_cs;
            r5_cell[0] <= w5_r2[DB-1:0];
            r5_cell[1] <= DB'(r4_rest - w5_rd[IDX_W-1:0]);
            r5_cell[2] <= r4_cell2;

            r6_ok    <= r5_ok;
            r6_total <= r5_total;
            r6_cs    <= r5_cs;
            r6_cell  <= r5_cell;
            for (int a = 0; a < 3; a++) begin
                r6_prod[a] <= C'(C'(r5_cell[a]) * r5_cs[a]);
                r6_last[a] <= (r5_cell[a] == r5_div[a] - DB'(1));
            end

            r7_ok    <= r6_ok;
            r7_total <= w7_total[TOTAL_W-1:0];
            for (int a = 0; a < 3; a++) begin
                if (r6_ok) begin
                    r7_cell[a] <= w7_cell[a][CELL_W-1:0];
                    r7_bmin[a] <= w7_bmin[a];
                    r7_bmax[a] <= r6_last[a] ? w_hi[a] : w7_bmin[a] + r6_cs[a];
                end else begin
                    r7_cell[a] <= '0;
                    r7_bmin[a] <= '0;
                    r7_bmax[a] <= '0;
                end
            end
        end
    end

    assign o_rsp.valid       = r7_v;
    assign o_rsp.index_valid = r7_ok;
    assign o_rsp.cell_x      = r7_cell[0];
    assign o_rsp.cell_y      = r7_cell[1];
    assign o_rsp.cell_z      = r7_cell[2];
    assign o_rsp.box_min_x   = r7_bmin[0];
    assign o_rsp.box_min_y   = r7_bmin[1];
    assign o_rsp.box_min_z   = r7_bmin[2];
    assign o_rsp.box_max_x   = r7_bmax[0];
    assign o_rsp.box_max_y   = r7_bmax[1];
    assign o_rsp.box_max_z   = r7_bmax[2];
    assign o_rsp.chunk_total = r7_total;

endmodule
